[rtl/dmae_pkg.sv]
// dmae_pkg: shared types, constants and the fnv fix-up for the dag mix access engine
// no dependencies
package dmae_pkg;

    localparam int unsigned ACCESS_COUNT = 64;
    localparam int unsigned ACC_W = 7;
    localparam int unsigned ROW_W = 27;
    localparam logic [26:0] ROW_COUNT_RESET = 27'd8388607;
    localparam logic [31:0] FNV_MULT = 32'h0100_0193;
    localparam logic [31:0] FNV_MOD_ALL = 32'hffff_ffff;

    localparam logic ACT_HEADER = 1'b0;
    localparam logic ACT_DATASET = 1'b1;
    localparam logic KIND_ROW = 1'b0;
    localparam logic KIND_MIX = 1'b1;

    // front-to-back queue entry
    typedef struct packed {
        logic        last_hdr;
        logic        last_word;
        logic [3:0]  idx;
        logic        action;
        logic [31:0] word;
    } dmae_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_REQ,
        ST_DIV,
        ST_OUT_REQ,
        ST_FOLD,
        ST_OUT_MIX
    } dmae_state_t;

    function automatic logic [31:0] fnv_fix(input logic [31:0] r);
        fnv_fix = (r == FNV_MOD_ALL) ? 32'd0 : r;
    endfunction

endpackage

[rtl/dag_mix_access_engine.sv]
// dag_mix_access_engine: top level of the dag mix access engine
// depends on dmae_pkg, dmae_front, dmae_queue, dmae_back
//
// Load eight hashed header words (tuser 0), then stream 16 dataset words
// (tuser 1) per row request; after 64 accesses four compressed mix words
// follow, the fourth with tlast. A dataset word passes the back end as a
// pop and then a read-multiply-write of the mix store; a header word is
// written to the lower half and then to the upper half. Each row request
// then runs the multiply, the fnv fix-up and the one-bit-per-cycle modulo
// by row_count, and a load of the output register. The final fold runs
// four fold steps per compressed word and one load of the output register.
// A four-entry queue decouples input acceptance from the back end; the
// output register lets the next input transfer proceed while a result
// waits.
module dag_mix_access_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [26:0] cfg_wdata,       // row_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // data_word
    input  logic        s_axis_tuser,    // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // value
    output logic        m_axis_tuser,    // kind
    output logic        m_axis_tlast     // last
);
    logic [26:0]         row_count_reg;
    logic                q_push, q_full, q_pop, q_valid;
    dmae_pkg::dmae_cmd_t q_in, q_out;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_count_reg <= dmae_pkg::ROW_COUNT_RESET;
        else if (cfg_we)
            row_count_reg <= cfg_wdata;
    end

    // front end: classify and count each input transfer
    dmae_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_word   (s_axis_tdata),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    dmae_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    // back end: mix store, fnv, modulo and output transfer
    dmae_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .row_count (row_count_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_value (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );
endmodule

[rtl/dmae_front.sv]
// dmae_front: accepts input transfers, drops items of the wrong kind, tags them
// depends on dmae_pkg
module dmae_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_action,
    input  logic [31:0]         in_word,
    output logic                q_push,
    output dmae_pkg::dmae_cmd_t q_data,
    input  logic                q_full
);
    // front tracks the phase itself; absorb ends after the last dataset word
    logic       absorb_reg, absorb_next;
    logic [2:0] hcnt_reg, hcnt_next;
    logic [3:0] wcnt_reg, wcnt_next;
    logic [dmae_pkg::ACC_W-1:0] acnt_reg, acnt_next;
    logic       acc;
    logic       match;

    assign in_ready = !q_full;
    assign acc = in_valid && !q_full;
    assign match = absorb_reg ? (in_action == dmae_pkg::ACT_DATASET)
                              : (in_action == dmae_pkg::ACT_HEADER);

    always_comb
    begin
        absorb_next = absorb_reg;
        hcnt_next = hcnt_reg;
        wcnt_next = wcnt_reg;
        acnt_next = acnt_reg;
        q_push = acc && match;
        q_data.word = in_word;
        q_data.action = in_action;
        q_data.idx = absorb_reg ? wcnt_reg : {1'b0, hcnt_reg};
        q_data.last_hdr = !absorb_reg && (hcnt_reg == 3'd7);
        q_data.last_word = absorb_reg && (wcnt_reg == 4'd15)
            && (acnt_reg == dmae_pkg::ACC_W'(dmae_pkg::ACCESS_COUNT - 1));
        if (acc && match)
        begin
            if (!absorb_reg)
            begin
                hcnt_next = hcnt_reg + 3'd1;
                if (hcnt_reg == 3'd7)
                begin
                    absorb_next = 1'b1;
                    wcnt_next = '0;
                    acnt_next = '0;
                end
            end
            else
            begin
                wcnt_next = wcnt_reg + 4'd1;
                if (wcnt_reg == 4'd15)
                begin
                    acnt_next = acnt_reg + dmae_pkg::ACC_W'(1);
                    if (q_data.last_word)
                    begin
                        absorb_next = 1'b0;
                        hcnt_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            absorb_reg <= 1'b0;
            hcnt_reg <= '0;
            wcnt_reg <= '0;
            acnt_reg <= '0;
        end
        else
        begin
            absorb_reg <= absorb_next;
            hcnt_reg <= hcnt_next;
            wcnt_reg <= wcnt_next;
            acnt_reg <= acnt_next;
        end
    end
endmodule

[rtl/dmae_queue.sv]
// dmae_queue: four-entry fifo between front and back
// depends on dmae_pkg
module dmae_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dmae_pkg::dmae_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output dmae_pkg::dmae_cmd_t pop_data
);
    dmae_pkg::dmae_cmd_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       do_push, do_pop;

    assign full = (cnt_reg == 3'd4);
    assign not_empty = (cnt_reg != 3'd0);
    assign pop_data = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= wp_reg + 2'd1;
            if (do_pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, do_push} - {2'b0, do_pop};
        end
    end
endmodule

[rtl/dmae_back.sv]
// dmae_back: mix store, fnv multiplier, serial row modulo and result register
// depends on dmae_pkg
module dmae_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  dmae_pkg::dmae_cmd_t q_data,
    output logic                q_pop,
    input  logic [26:0]         row_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_kind,
    output logic [31:0]         out_value,
    output logic                out_last
);
    logic [31:0] mix_reg [16];
    logic [31:0] hfirst_reg, hfirst_next;
    logic [dmae_pkg::ACC_W-1:0] acnt_reg, acnt_next;
    dmae_pkg::dmae_state_t st_reg, st_next;
    dmae_pkg::dmae_cmd_t cmd_reg, cmd_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [26:0] div_reg, div_next;
    logic [5:0]  bit_reg, bit_next;
    logic [1:0]  grp_reg, grp_next;
    logic [1:0]  sub_reg, sub_next;
    logic [31:0] acc_reg, acc_next;
    logic        ov_reg, ov_next;
    logic        ok_reg, ok_next;
    logic [31:0] ovl_reg, ovl_next;
    logic        ol_reg, ol_next;
    logic        mix_we;
    logic [3:0]  mix_wa;
    logic [31:0] mix_wd;
    logic [31:0] mul_a, mul_b;
    logic [32:0] trial;
    logic [3:0]  fidx;
    logic        out_free;

    assign out_valid = ov_reg;
    assign out_kind = ok_reg;
    assign out_value = ovl_reg;
    assign out_last = ol_reg;
    assign out_free = !ov_reg || out_ready;
    assign trial = {rem_reg, quo_reg[31]} - {6'd0, div_reg};
    assign fidx = {grp_reg, sub_reg};

    always_comb
    begin
        st_next = st_reg;
        cmd_next = cmd_reg;
        hfirst_next = hfirst_reg;
        acnt_next = acnt_reg;
        prod_next = prod_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        bit_next = bit_reg;
        grp_next = grp_reg;
        sub_next = sub_reg;
        acc_next = acc_reg;
        ov_next = ov_reg && !out_ready;
        ok_next = ok_reg;
        ovl_next = ovl_reg;
        ol_next = ol_reg;
        q_pop = 1'b0;
        mix_we = 1'b0;
        mix_wa = cmd_reg.idx;
        mix_wd = cmd_reg.word;
        mul_a = mix_reg[cmd_reg.idx];
        mul_b = dmae_pkg::FNV_MULT;
        case (st_reg)
            dmae_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    cmd_next = q_data;
                    if (q_data.action == dmae_pkg::ACT_HEADER)
                    begin
                        // header word goes to the lower half now and to the upper half in ST_MUL
                        mix_we = 1'b1;
                        mix_wa = q_data.idx;
                        mix_wd = q_data.word;
                        if (q_data.idx == 4'd0)
                            hfirst_next = q_data.word;
                        st_next = dmae_pkg::ST_MUL;
                    end
                    else
                        st_next = dmae_pkg::ST_MUL;
                end
            end
            dmae_pkg::ST_MUL:
            begin
                if (cmd_reg.action == dmae_pkg::ACT_HEADER)
                begin
                    mix_we = 1'b1;
                    mix_wa = {1'b1, cmd_reg.idx[2:0]};
                    if (cmd_reg.last_hdr)
                    begin
                        acnt_next = '0;
                        st_next = dmae_pkg::ST_REQ;
                    end
                    else
                        st_next = dmae_pkg::ST_IDLE;
                end
                else
                begin
                    mix_we = 1'b1;
                    mix_wd = dmae_pkg::fnv_fix((mul_a * mul_b) ^ cmd_reg.word);
                    if (cmd_reg.idx != 4'd15)
                        st_next = dmae_pkg::ST_IDLE;
                    else if (cmd_reg.last_word)
                    begin
                        grp_next = '0;
                        sub_next = '0;
                        st_next = dmae_pkg::ST_FOLD;
                    end
                    else
                    begin
                        acnt_next = acnt_reg + dmae_pkg::ACC_W'(1);
                        st_next = dmae_pkg::ST_REQ;
                    end
                end
            end
            dmae_pkg::ST_REQ:
            begin
                // product registered before the xor and the modulo
                mul_a = {25'd0, acnt_reg} ^ hfirst_reg;
                prod_next = mul_a * mul_b;
                quo_next = mix_reg[acnt_reg[3:0]];
                st_next = dmae_pkg::ST_DIV;
                bit_next = '0;
                rem_next = '0;
                div_next = (row_count == 27'd0) ? 27'd1 : row_count;
            end
            dmae_pkg::ST_DIV:
            begin
                if (bit_reg == 6'd0)
                    quo_next = dmae_pkg::fnv_fix(prod_reg ^ quo_reg);
                else
                begin
                    // one restoring step per cycle, remainder only
                    quo_next = {quo_reg[30:0], 1'b0};
                    if (!trial[32])
                        rem_next = trial[31:0];
                    else
                        rem_next = {rem_reg[30:0], quo_reg[31]};
                end
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd32)
                    st_next = dmae_pkg::ST_OUT_REQ;
            end
            dmae_pkg::ST_OUT_REQ:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ok_next = dmae_pkg::KIND_ROW;
                    ovl_next = rem_reg;
                    ol_next = 1'b0;
                    st_next = dmae_pkg::ST_IDLE;
                end
            end
            dmae_pkg::ST_FOLD:
            begin
                mul_a = (sub_reg == 2'd0) ? mix_reg[fidx] : acc_reg;
                if (sub_reg == 2'd0)
                    acc_next = mix_reg[fidx];
                else
                    acc_next = dmae_pkg::fnv_fix(prod_reg ^ mix_reg[fidx]);
                prod_next = ((sub_reg == 2'd0) ? mix_reg[fidx] : acc_next) * mul_b;
                if (sub_reg == 2'd3)
                    st_next = dmae_pkg::ST_OUT_MIX;
                sub_next = sub_reg + 2'd1;
            end
            dmae_pkg::ST_OUT_MIX:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ok_next = dmae_pkg::KIND_MIX;
                    ovl_next = acc_reg;
                    ol_next = (grp_reg == 2'd3);
                    grp_next = grp_reg + 2'd1;
                    st_next = (grp_reg == 2'd3) ? dmae_pkg::ST_IDLE : dmae_pkg::ST_FOLD;
                end
            end
            default:
            begin
                st_next = dmae_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mix_we)
            mix_reg[mix_wa] <= mix_wd;
        cmd_reg <= cmd_next;
        hfirst_reg <= hfirst_next;
        prod_reg <= prod_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        acc_reg <= acc_next;
        ovl_reg <= ovl_next;
        ok_reg <= ok_next;
        ol_reg <= ol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= dmae_pkg::ST_IDLE;
            acnt_reg <= '0;
            bit_reg <= '0;
            grp_reg <= '0;
            sub_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            acnt_reg <= acnt_next;
            bit_reg <= bit_next;
            grp_reg <= grp_next;
            sub_reg <= sub_next;
            ov_reg <= ov_next;
        end
    end
endmodule

[tb/dag_mix_access_engine_test.sv]
// dag_mix_access_engine_test: self-checking testbench for the dag mix access engine
// depends on dmae_pkg and dag_mix_access_engine; a header and its dataset words
// are streamed in and every row request and compressed mix word is checked
`timescale 1ns / 100ps

module dag_mix_access_engine_test;

    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 200;

    typedef struct {
        logic        kind;
        logic [31:0] value;
        logic        last;
    } mix_result_t;

    // running copy of the engine: mix store, counters and row count
    class mix_scoreboard;
        logic [31:0] mix[16];
        logic [31:0] header_first;
        int unsigned header_n;
        int unsigned word_n;
        int unsigned access_n;
        bit          absorbing;
        logic [26:0] rows;
        mix_result_t pending[$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned requests_seen;
        int unsigned mix_words_seen;

        function new();
            foreach (mix[k])
                mix[k] = '0;
            header_first = '0;
            header_n = 0;
            word_n = 0;
            access_n = 0;
            absorbing = 1'b0;
            rows = dmae_pkg::ROW_COUNT_RESET;
            mismatches = 0;
            results_seen = 0;
            requests_seen = 0;
            mix_words_seen = 0;
        endfunction

        function logic [31:0] fnv(input logic [31:0] a, input logic [31:0] b);
            logic [31:0] r;
            r = (a * dmae_pkg::FNV_MULT) ^ b;
            return (r == dmae_pkg::FNV_MOD_ALL) ? 32'd0 : r;
        endfunction

        function void queue_row_request();
            mix_result_t e;
            logic [31:0] divisor;
            logic [31:0] acc;
            divisor = (rows == '0) ? 32'd1 : {5'd0, rows};
            acc = access_n;
            e.kind = dmae_pkg::KIND_ROW;
            e.value = fnv(acc ^ header_first, mix[access_n % 16]) % divisor;
            e.last = 1'b0;
            pending.push_back(e);
        endfunction

        // a transfer the engine has accepted
        function void note_input(input logic action, input logic [31:0] word);
            mix_result_t e;
            logic [31:0] c;
            if (!absorbing)
            begin
                if (action != dmae_pkg::ACT_HEADER)
                    return;
                if (header_n == 0)
                    header_first = word;
                mix[header_n] = word;
                mix[header_n + 8] = word;
                if (header_n == 7)
                begin
                    header_n = 0;
                    word_n = 0;
                    access_n = 0;
                    absorbing = 1'b1;
                    queue_row_request();
                end
                else
                    header_n++;
                return;
            end
            if (action != dmae_pkg::ACT_DATASET)
                return;
            mix[word_n] = fnv(mix[word_n], word);
            if (word_n != 15)
            begin
                word_n++;
                return;
            end
            word_n = 0;
            if (access_n + 1 < dmae_pkg::ACCESS_COUNT)
            begin
                access_n++;
                queue_row_request();
                return;
            end
            for (int g = 0; g < 4; g++)
            begin
                c = fnv(mix[4*g], mix[4*g+1]);
                c = fnv(c, mix[4*g+2]);
                c = fnv(c, mix[4*g+3]);
                e.kind = dmae_pkg::KIND_MIX;
                e.value = c;
                e.last = (g == 3);
                pending.push_back(e);
            end
            access_n = 0;
            header_n = 0;
            absorbing = 1'b0;
        endfunction

        function void report(input string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        // a transfer the engine has produced
        function void check_result(input logic kind, input logic [31:0] value,
                                   input logic last);
            mix_result_t e;
            results_seen++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result kind=%0b value=%h last=%0b",
                                 kind, value, last));
                return;
            end
            e = pending.pop_front();
            if (e.kind == dmae_pkg::KIND_ROW)
                requests_seen++;
            else
                mix_words_seen++;
            if (kind !== e.kind || value !== e.value || last !== e.last)
                report($sformatf("expected kind=%0b value=%h last=%0b, got kind=%0b value=%h last=%0b",
                                 e.kind, e.value, e.last, kind, value, last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [26:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // data_word
    logic        s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // value
    logic        m_axis_tuser;   // kind
    logic        m_axis_tlast;   // last

    mix_scoreboard sb;
    bit            gaps_on;          // random idling on both sides
    bit            hold_done;        // receiver back-pressure stretch taken
    int unsigned   hold_left;
    int unsigned   quiet_cycles;     // cycles with no transfer on either side
    int unsigned   items_sent;
    int unsigned   noise_sent;

    dag_mix_access_engine u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: checks each result transfer and decides tready for the next edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            // one long hold-off early on, so the input queue fills and stalls
            if (!hold_done && sb.results_seen == 20)
            begin
                hold_done <= 1'b1;
                hold_left <= 400;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= (hold_left == 1);
            end
            else
                m_axis_tready <= !(gaps_on && $urandom_range(99) < 10);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAIL dag_mix_access_engine");
                $finish;
            end
        end
    end

    // offers one item and waits for its transfer; tvalid stays high afterwards
    task automatic send_word(input logic action, input logic [31:0] word);
        while (gaps_on && $urandom_range(99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= action;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(action, word);
        items_sent++;
    endtask

    // word pattern: 0 random, 1 all zeros, 2 all ones, 3 alternating extremes
    function automatic logic [31:0] pick_word(input int pattern, input int unsigned n);
        case (pattern)
            1: return 32'h0000_0000;
            2: return 32'hffff_ffff;
            3: return n[0] ? 32'hffff_ffff : 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // wrong-kind item: ignored by the engine
    task automatic send_noise(input logic action);
        send_word(action, $urandom());
        noise_sent++;
    endtask

    // waits until every expected result has come, then lets the engine settle
    task automatic wait_idle();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_rows(input logic [26:0] rows);
        cfg_we <= 1'b1;
        cfg_wdata <= rows;
        @(posedge clk);
        sb.rows = rows;
        cfg_we <= 1'b0;
    endtask

    // stops offering, lets the engine drain, then changes the row count
    task automatic pause_and_write(input logic [26:0] rows);
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_rows(rows);
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = dmae_pkg::ACT_HEADER;
        m_axis_tready = 1'b0;
        gaps_on = 1'b1;
        hold_done = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
        items_sent = 0;
        noise_sent = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray dataset words before any header
        send_noise(dmae_pkg::ACT_DATASET);
        send_noise(dmae_pkg::ACT_DATASET);

        // header of alternating extreme words, reset row count at first
        for (int h = 0; h < 8; h++)
        begin
            if ($urandom_range(99) < 3)
                send_noise(dmae_pkg::ACT_DATASET);
            send_word(dmae_pkg::ACT_HEADER, pick_word(3, unsigned'(h)));
        end

        // every access, row count changed between accesses while idle
        for (int a = 0; a < dmae_pkg::ACCESS_COUNT; a++)
        begin
            case (a)
                8: pause_and_write(27'd1);
                16: pause_and_write(27'd0);
                24: pause_and_write(27'h7ff_ffff);
                32: pause_and_write(27'd67108864);
                40: pause_and_write(27'($urandom_range(1000, 1)));
                default: ;
            endcase
            // last quarter runs with no idling at all
            gaps_on = (a < 48);
            for (int w = 0; w < 16; w++)
            begin
                if ($urandom_range(99) < 3)
                    send_noise(dmae_pkg::ACT_HEADER);
                send_word(dmae_pkg::ACT_DATASET, pick_word(a % 4, unsigned'(a * 16 + w)));
            end
        end
        s_axis_tvalid <= 1'b0;
        gaps_on = 1'b1;
        wait_idle();

        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));
        $display("covered %0d input transfers (%0d stray), %0d row requests, %0d mix words",
                 items_sent, noise_sent, sb.requests_seen, sb.mix_words_seen);
        $display("row counts reset, 1, 0, full width and random; one long output hold-off");
        if (sb.mismatches == 0)
            $display("PASS dag_mix_access_engine");
        else
            $display("FAIL dag_mix_access_engine");
        $finish;
    end

endmodule
